>>> sv/indexed_list_store_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list store
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ILST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ILST_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ilst_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Field widths, request and status codes, and the cell command type.
// ----------------------------------------------------------------------------
package ilst_pkg;

  localparam int REQ_W   = 2;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int FPOS_W  = 6;
  localparam int CNT_W   = 7;
  localparam int CELL_OP_W = 3;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  localparam logic [CELL_OP_W-1:0] CELL_HOLD    = 3'd0;
  localparam logic [CELL_OP_W-1:0] CELL_INSERT  = 3'd1;
  localparam logic [CELL_OP_W-1:0] CELL_REMOVE  = 3'd2;
  localparam logic [CELL_OP_W-1:0] CELL_COMPARE = 3'd3;
  localparam logic [CELL_OP_W-1:0] CELL_SCAN    = 3'd4;
  localparam logic [CELL_OP_W-1:0] CELL_WRITE   = 3'd5;

  typedef struct packed {
    logic [CELL_OP_W-1:0] op;
    logic [POS_W-1:0]     pos;
    logic [VAL_W-1:0]     value;
  } cell_cmd_t;

endpackage

>>> sv/ilst_if.sv
// ----------------------------------------------------------------------------
// Indexed list store channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ilst_in_if
  import ilst_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;
  logic signed [VAL_W-1:0] replacement;

  modport source (output valid, req_type, position, item_value, replacement,
                  input ready);
  modport sink (input valid, req_type, position, item_value, replacement,
                output ready);
endinterface

interface ilst_out_if
  import ilst_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [FPOS_W-1:0] found_position;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, status, found_position, entry_count,
                  input ready);
  modport sink (input valid, status, found_position, entry_count,
                output ready);
endinterface

>>> sv/ilst_cell.sv
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one entry and one match flag; shifts with its neighbors on command.
// ----------------------------------------------------------------------------
module ilst_cell
  import ilst_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] prev_entry,
  input  logic [VAL_W-1:0] next_entry,
  input  logic             next_match,
  input  logic             wr_sel,
  output logic [VAL_W-1:0] entry,
  output logic             match
);

  localparam int IDX_W = 11;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [VAL_W-1:0] entry_r, entry_nxt;
  logic             match_r, match_nxt;
  logic [IDX_W-1:0] pos_ext;

  assign pos_ext = IDX_W'(cmd.pos);

  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX > pos_ext) begin
          entry_nxt = prev_entry;
        end else if (MY_IDX == pos_ext) begin
          entry_nxt = cmd.value;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= pos_ext) begin
          entry_nxt = next_entry;
        end
      end
      CELL_COMPARE: begin
        match_nxt = (entry_r == cmd.value);
      end
      CELL_SCAN: begin
        match_nxt = next_match;
      end
      CELL_WRITE: begin
        if (wr_sel) begin
          entry_nxt = cmd.value;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

>>> sv/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// Indexed list store core
// Fixed-capacity list held in a row of cells with insert, remove, find and
// modify requests.
// ----------------------------------------------------------------------------
// Insert and remove results are registered: the result is valid the cycle after accept.
// Find and modify compare all entries on accept, then shift match flags toward
// cell 0 until cell 0 matches or the count is reached; modify rewrites that cell.
// A new request is taken in the cycle that the previous result item is accepted.
// Synchronous active-low reset clears the count, the scan control and the
// output valid; entry contents are undefined until written.
module indexed_list_store_core
  import ilst_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ilst_in_if.sink     in_ch,
  ilst_out_if.source  out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic              modify_r, modify_nxt;
  logic [VAL_W-1:0]  rep_r, rep_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [FPOS_W-1:0] where_r, where_nxt;
  logic [CNT_W-1:0]  cnt_out_r, cnt_out_nxt;

  logic              in_ready;
  logic              in_fire;
  logic              found;
  logic [CW-1:0]     scan_inc;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_ext;
  cell_cmd_t         cmd;

  logic [VAL_W-1:0]  entry_w [CAPACITY];
  logic              match_w [CAPACITY];
  logic [CAPACITY-1:0] wr_sel;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign pos_ext  = PW'(in_ch.position);
  assign cnt_ext  = PW'(count_r);
  assign scan_inc = scan_r + CW'(1);
  assign found    = match_w[0] && (count_r != '0);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    modify_nxt    = modify_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    where_nxt     = where_r;
    cnt_out_nxt   = cnt_out_r;
    cmd.op        = CELL_HOLD;
    cmd.pos       = in_ch.position;
    cmd.value     = in_ch.item_value;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.req_type)
            REQ_INSERT: begin
              status_nxt = ST_OK;
              if (pos_ext > cnt_ext) begin
                status_nxt = ST_RANGE;
              end else if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.op    = CELL_INSERT;
                count_nxt = count_r + CW'(1);
              end
              out_valid_nxt = 1'b1;
              where_nxt     = in_ch.position[FPOS_W-1:0];
              cnt_out_nxt   = CNT_W'(count_nxt);
            end
            REQ_REMOVE: begin
              status_nxt = ST_OK;
              if (pos_ext >= cnt_ext) begin
                status_nxt = ST_RANGE;
              end else begin
                cmd.op    = CELL_REMOVE;
                count_nxt = count_r - CW'(1);
              end
              out_valid_nxt = 1'b1;
              where_nxt     = in_ch.position[FPOS_W-1:0];
              cnt_out_nxt   = CNT_W'(count_nxt);
            end
            default: begin
              cmd.op     = CELL_COMPARE;
              state_nxt  = S_SCAN;
              scan_nxt   = '0;
              modify_nxt = (in_ch.req_type == REQ_MODIFY);
              rep_nxt    = in_ch.replacement;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.value = rep_r;
        if (found) begin
          if (modify_r) begin
            cmd.op = CELL_WRITE;
          end
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          where_nxt     = FPOS_W'(scan_r);
          cnt_out_nxt   = CNT_W'(count_r);
        end else if (scan_inc >= count_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_MISSING;
          where_nxt     = '0;
          cnt_out_nxt   = CNT_W'(count_r);
        end else begin
          cmd.op   = CELL_SCAN;
          scan_nxt = scan_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    modify_r  <= modify_nxt;
    rep_r     <= rep_nxt;
    status_r  <= status_nxt;
    where_r   <= where_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [VAL_W-1:0] prev_e;
      logic [VAL_W-1:0] next_e;
      logic             next_m;

      if (gi == 0) begin : g_first
        assign prev_e = '0;
      end else begin : g_mid
        assign prev_e = entry_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign next_e = '0;
        assign next_m = 1'b0;
      end else begin : g_body
        assign next_e = entry_w[gi+1];
        assign next_m = match_w[gi+1];
      end

      assign wr_sel[gi] = (scan_r == CW'(gi));

      ilst_cell #(
        .IDX (gi)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .next_match (next_m),
        .wr_sel     (wr_sel[gi]),
        .entry      (entry_w[gi]),
        .match      (match_w[gi])
      );
    end
  endgenerate

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.found_position = where_r;
  assign out_ch.entry_count    = cnt_out_r;

endmodule

>>> sv/ilst_checker.sv
// ----------------------------------------------------------------------------
// Indexed list store port checker
// Checks result channel behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "indexed_list_store_core_macros.svh"

module ilst_checker
  import ilst_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ST_W-1:0]   status,
  input logic [FPOS_W-1:0] found_position,
  input logic [CNT_W-1:0]  entry_count
);

  `ILST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_position) && $stable(entry_count), "stalled result item changed")
  `ILST_ASSERT_IMPL(a_ready_slot, in_ready && out_valid, out_ready, "item accepted while result slot blocked")
  `ILST_ASSERT_IMPL(a_full_count, out_valid && (status == ST_FULL), entry_count == CNT_W'(CAPACITY), "full status without full count")
  `ILST_ASSERT_IMPL(a_missing_pos, out_valid && (status == ST_MISSING), found_position == '0, "missing value with nonzero index")
  `ILST_ASSERT_RST(a_reset_idle, !rst_n, !out_valid, "result valid after reset")

endmodule

bind indexed_list_store_core ilst_checker #(
  .CAPACITY (CAPACITY)
) u_ilst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .found_position (out_ch.found_position),
  .entry_count    (out_ch.entry_count)
);
